@@ src/sobel_et_pkg.sv @@
// Shared types, constants and helpers for the Sobel edge threshold block.
`timescale 1ns / 1ps

package sobel_et_pkg;

    // Default geometry limits
    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_HEIGHT = 4096;
    localparam int MIN_WIDTH      = 3;

    // Field widths
    localparam int PIX_W    = 8;
    localparam int OCOL_W   = 11;
    localparam int OROW_W   = 12;
    localparam int GRAD_W   = 11;
    localparam int SQ_W     = 20;
    localparam int SUM_W    = 21;
    localparam int LIM_W    = 23;
    localparam int LW_W     = 12;
    localparam int THR_W    = 11;
    localparam int CFG_W    = 12;
    localparam int CFG_IDX_W = 4;

    // Register reset values
    localparam logic [LW_W-1:0]  LINE_WIDTH_RST = 12'd2048;
    localparam logic [THR_W-1:0] THRESHOLD_RST  = 11'd128;
    localparam logic [LIM_W-1:0] LIMIT_RST      = 23'd16641; // (128 + 1)^2

    localparam logic [PIX_W-1:0] EDGE_ON  = 8'd255;
    localparam logic [PIX_W-1:0] EDGE_OFF = 8'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LINE_WIDTH     = 4'd0,
        CFG_EDGE_THRESHOLD = 4'd1
    } cfg_idx_e;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             frame_start;
    } pix_t;

    typedef struct packed {
        logic [PIX_W-1:0]  edge_value;
        logic [OCOL_W-1:0] centre_column;
        logic [OROW_W-1:0] centre_row;
    } res_t;

    // Gradient pair for one interior centre
    typedef struct packed {
        logic signed [GRAD_W-1:0] gx;
        logic signed [GRAD_W-1:0] gy;
        logic [OCOL_W-1:0]        centre_column;
        logic [OROW_W-1:0]        centre_row;
    } grad_t;

endpackage

@@ src/sobel_et_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module sobel_et_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 2048
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem_reg [0:DEPTH-1];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/sobel_et_front.sv @@
// Position counters, line stores, 3x3 window and Sobel gradient stage.
`timescale 1ns / 1ps

module sobel_et_front
    import sobel_et_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            pix_valid,
    input  pix_t            pix_data,
    output logic            pix_ready,
    input  logic [LW_W-1:0] line_width,
    output logic            grad_valid,
    output grad_t           grad_data,
    input  logic            grad_take
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int AW    = (COL_W + 1 > LW_W) ? COL_W + 1 : LW_W;
    localparam int CW    = (COL_W > OCOL_W) ? COL_W : OCOL_W;
    localparam int RW    = (ROW_W > OROW_W) ? ROW_W : OROW_W;

    logic [COL_W-1:0] col_reg, col_next, col_cur;
    logic [ROW_W-1:0] row_reg, row_next, row_cur;
    logic [AW-1:0]    width_ext, width_act, col_inc;
    logic             accept;

    // stage 1: accepted pixel, line-store data arrives alongside
    logic             s1_v_reg;
    logic [PIX_W-1:0] s1_px_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic [ROW_W-1:0] s1_row_reg;
    logic [2*PIX_W-1:0] ls_rd;
    logic             s1_move, en1, en2, interior;

    logic [PIX_W-1:0] win0_reg [0:2];
    logic [PIX_W-1:0] win1_reg [0:2];
    logic [PIX_W-1:0] top2, mid2;

    logic [GRAD_W-1:0] t0, t1, t2, m0, m2, b0, b1, b2;
    logic signed [GRAD_W-1:0] gx_next, gy_next;
    logic [CW-1:0] ctr_col;
    logic [RW-1:0] ctr_row;

    logic  grad_v_reg;
    grad_t grad_reg;

    assign en2       = !grad_v_reg || grad_take;
    assign en1       = !s1_v_reg || en2;
    assign pix_ready = en1;
    assign accept    = pix_valid && en1;
    assign s1_move   = s1_v_reg && en2;

    assign col_cur = pix_data.frame_start ? '0 : col_reg;
    assign row_cur = pix_data.frame_start ? '0 : row_reg;

    // clamp line width to [MIN_WIDTH, MAX_WIDTH]
    assign width_ext = AW'(line_width);
    always_comb
    begin
        if (width_ext < AW'(MIN_WIDTH))
            width_act = AW'(MIN_WIDTH);
        else if (width_ext > AW'(MAX_WIDTH))
            width_act = AW'(MAX_WIDTH);
        else
            width_act = width_ext;
    end

    assign col_inc = AW'(col_cur) + AW'(1);

    always_comb
    begin
        if (col_inc >= width_act)
        begin
            col_next = '0;
            row_next = (row_cur == ROW_W'(MAX_HEIGHT - 1)) ? '0 : row_cur + ROW_W'(1);
        end
        else
        begin
            col_next = col_cur + COL_W'(1);
            row_next = row_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // {older row, previous row} per column; read on accept, rewritten as the item leaves stage 1
    sobel_et_ram #(
        .DATA_W (2 * PIX_W),
        .DEPTH  (MAX_WIDTH)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (s1_move),
        .wr_addr (s1_col_reg),
        .wr_data ({ls_rd[PIX_W-1:0], s1_px_reg}),
        .rd_en   (accept),
        .rd_addr (col_cur),
        .rd_data (ls_rd)
    );

    assign top2 = ls_rd[2*PIX_W-1:PIX_W];
    assign mid2 = ls_rd[PIX_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
        end
        else if (en1)
        begin
            s1_v_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_px_reg  <= pix_data.pixel;
            s1_col_reg <= col_cur;
            s1_row_reg <= row_cur;
        end
    end

    // window: win0 two columns back, win1 one column back (top, mid, bottom)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win0_reg[i] <= '0;
                win1_reg[i] <= '0;
            end
        end
        else if (s1_move)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win0_reg[i] <= win1_reg[i];
            end
            win1_reg[0] <= top2;
            win1_reg[1] <= mid2;
            win1_reg[2] <= s1_px_reg;
        end
    end

    assign interior = (s1_col_reg >= COL_W'(2)) && (s1_row_reg >= ROW_W'(2));

    assign t0 = GRAD_W'(win0_reg[0]);
    assign t1 = GRAD_W'(win1_reg[0]);
    assign t2 = GRAD_W'(top2);
    assign m0 = GRAD_W'(win0_reg[1]);
    assign m2 = GRAD_W'(mid2);
    assign b0 = GRAD_W'(win0_reg[2]);
    assign b1 = GRAD_W'(win1_reg[2]);
    assign b2 = GRAD_W'(s1_px_reg);

    // results fit in 11 bits signed, so modulo arithmetic is exact
    assign gx_next = $signed((t2 - t0) + ((m2 - m0) << 1) + (b2 - b0));
    assign gy_next = $signed((t0 + (t1 << 1) + t2) - (b0 + (b1 << 1) + b2));

    assign ctr_col = CW'(s1_col_reg) - CW'(1);
    assign ctr_row = RW'(s1_row_reg) - RW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grad_v_reg <= 1'b0;
        end
        else if (en2)
        begin
            grad_v_reg <= s1_v_reg && interior;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2 && s1_v_reg && interior)
        begin
            grad_reg.gx            <= gx_next;
            grad_reg.gy            <= gy_next;
            grad_reg.centre_column <= ctr_col[OCOL_W-1:0];
            grad_reg.centre_row    <= ctr_row[OROW_W-1:0];
        end
    end

    assign grad_valid = grad_v_reg;
    assign grad_data  = grad_reg;

endmodule

@@ src/sobel_et_decide.sv @@
// Squared magnitude, threshold compare and result register.
`timescale 1ns / 1ps

module sobel_et_decide
    import sobel_et_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             grad_valid,
    input  grad_t            grad_data,
    output logic             grad_take,
    input  logic [LIM_W-1:0] limit,
    output logic             res_valid,
    output res_t             res_data,
    input  logic             res_stall
);

    logic              sq_v_reg;
    logic [SQ_W-1:0]   gx2_reg, gy2_reg;
    logic [OCOL_W-1:0] sq_col_reg;
    logic [OROW_W-1:0] sq_row_reg;
    logic signed [2*GRAD_W-1:0] gx_sq, gy_sq;
    logic [SUM_W-1:0]  mag_sq;
    logic              en_out, en3;

    logic res_v_reg;
    res_t res_reg;

    assign en_out    = !res_v_reg || !res_stall;
    assign en3       = !sq_v_reg || en_out;
    assign grad_take = en3;

    assign gx_sq = grad_data.gx * grad_data.gx;
    assign gy_sq = grad_data.gy * grad_data.gy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_v_reg <= 1'b0;
        end
        else if (en3)
        begin
            sq_v_reg <= grad_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en3 && grad_valid)
        begin
            gx2_reg    <= gx_sq[SQ_W-1:0];
            gy2_reg    <= gy_sq[SQ_W-1:0];
            sq_col_reg <= grad_data.centre_column;
            sq_row_reg <= grad_data.centre_row;
        end
    end

    assign mag_sq = {1'b0, gx2_reg} + {1'b0, gy2_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_v_reg <= 1'b0;
        end
        else if (en_out)
        begin
            res_v_reg <= sq_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_out && sq_v_reg)
        begin
            res_reg.edge_value    <= (LIM_W'(mag_sq) >= limit) ? EDGE_ON : EDGE_OFF;
            res_reg.centre_column <= sq_col_reg;
            res_reg.centre_row    <= sq_row_reg;
        end
    end

    assign res_valid = res_v_reg;
    assign res_data  = res_reg;

endmodule

@@ src/sobel_edge_threshold.sv @@
// Top level of the 3x3 Sobel edge detector with integer magnitude threshold.
//
// Usage:
//   Pixel channel (pix_valid / pix_stall / pix_data): 8-bit grey pixels in
//   raster order; frame_start marks column 0, row 0 of a new image. A
//   transaction completes on a rising edge with pix_valid high and pix_stall low.
//   Result channel (res_valid / res_stall / res_data): one transaction per
//   interior centre, carrying 255 (edge) or 0 plus the centre coordinates.
//   Border pixels produce nothing. A centre is decided when the pixel one
//   row below and one column right of it arrives.
//   Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): index 0 is
//   line_width, index 1 is edge_threshold. Always ready; write only while idle.
//   Pipeline: four register stages (input + line-store read, gradients,
//   squares, compare/result), which the pixel completing its window passes
//   in order. One pixel per cycle sustained unless res_stall holds results;
//   each square uses one 11x11 multiplier, registered before the add/compare.
//   Back-pressure: each stage holds when the next is full and stalled, so
//   bubbles are absorbed and input continues until all stages fill.
//   Reset: position counters, window and valids clear; line_width = 2048,
//   edge_threshold = 128. Line stores are not cleared (read only after write).
`timescale 1ns / 1ps

module sobel_edge_threshold
    import sobel_et_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pix_valid,
    output logic                 pix_stall,
    input  pix_t                 pix_data,
    output logic                 res_valid,
    input  logic                 res_stall,
    output res_t                 res_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    logic [LW_W-1:0]  line_width_reg;
    logic [THR_W-1:0] thr_reg;
    logic [LIM_W-1:0] limit_reg, limit_next;
    logic [THR_W:0]   thr_plus;
    logic [2*THR_W+1:0] thr_sq;
    logic             cfg_wr;

    logic  pix_ready;
    logic  grad_valid, grad_take;
    grad_t grad_data;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    // register file decode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg <= LINE_WIDTH_RST;
            thr_reg        <= THRESHOLD_RST;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                CFG_LINE_WIDTH:     line_width_reg <= cfg_data[LW_W-1:0];
                CFG_EDGE_THRESHOLD: thr_reg        <= cfg_data[THR_W-1:0];
                default:            ;
            endcase
        end
    end

    // sqrt(gx^2+gy^2) >= t+1  <=>  gx^2+gy^2 >= (t+1)^2; limit is registered from thr_reg after a write
    assign thr_plus   = {1'b0, thr_reg} + (THR_W + 1)'(1);
    assign thr_sq     = thr_plus * thr_plus;
    assign limit_next = thr_sq[LIM_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RST;
        end
        else
        begin
            limit_reg <= limit_next;
        end
    end

    assign pix_stall = !pix_ready;

    sobel_et_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix_valid  (pix_valid),
        .pix_data   (pix_data),
        .pix_ready  (pix_ready),
        .line_width (line_width_reg),
        .grad_valid (grad_valid),
        .grad_data  (grad_data),
        .grad_take  (grad_take)
    );

    sobel_et_decide u_decide (
        .clk        (clk),
        .rst_n      (rst_n),
        .grad_valid (grad_valid),
        .grad_data  (grad_data),
        .grad_take  (grad_take),
        .limit      (limit_reg),
        .res_valid  (res_valid),
        .res_data   (res_data),
        .res_stall  (res_stall)
    );

endmodule

@@ tb/sv/sobel_edge_threshold_tb.sv @@
// Self-checking testbench for the Sobel edge threshold block.
`timescale 1ns / 1ps

module sobel_edge_threshold_tb;
    import sobel_et_pkg::*;

    localparam int HALF_PERIOD   = 10;      // 20 ns clock
    localparam int RESET_CYCLES  = 7;
    localparam int SETTLE_CYCLES = 8;       // pipeline is four stages deep
    localparam int DRAIN_LIMIT   = 50000;   // cycles to wait for outstanding results

    // Texture of the generated image content
    typedef enum int
    {
        TEX_UNIFORM,    // independent random levels, strong gradients
        TEX_BINARY,     // black/white only, extreme gradients
        TEX_SMOOTH      // small noise around one level, weak gradients
    } texture_e;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 pix_valid = 1'b0;
    logic                 pix_stall;
    pix_t                 pix_data = '0;
    logic                 res_valid;
    logic                 res_stall = 1'b0;
    res_t                 res_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    // Local copy of the detector state, updated on every accepted pixel transaction
    logic [PIX_W-1:0] older_row [DEF_MAX_WIDTH];    // row two above
    logic [PIX_W-1:0] newer_row [DEF_MAX_WIDTH];    // row one above
    logic [PIX_W-1:0] win_top [2];                  // [0] two columns back, [1] one back
    logic [PIX_W-1:0] win_mid [2];
    logic [PIX_W-1:0] win_bot [2];
    int unsigned      col_pos;
    int unsigned      row_pos;
    logic [LW_W-1:0]  width_reg;
    logic [THR_W-1:0] thresh_reg;

    res_t expected_edges [$];   // decisions in the order the block must deliver them
    res_t oldest_edge;
    int   error_count = 0;

    // Idle rates in percent; changed only while the block is quiet
    int send_pct  = 0;
    int stall_pct = 0;

    sobel_edge_threshold i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix_data  (pix_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // Result side back-pressure, one fresh draw per cycle
    always @(posedge clk)
    begin
        res_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Advance the local detector by one pixel and queue the decision it completes.
    // The pixel at (c, r), c >= 2 and r >= 2, closes the window of centre (c-1, r-1).
    task automatic predict_edge(input pix_t p);
        int         tl, tc, tr, ml, mr, bl, bc, br;
        int         gx, gy, mag_sq, limit_sq;
        int unsigned eff_width;
        res_t       decision;
        if (p.frame_start)
        begin
            col_pos = 0;
            row_pos = 0;
        end
        tl = win_top[0];
        tc = win_top[1];
        tr = older_row[col_pos];
        ml = win_mid[0];
        mr = newer_row[col_pos];
        bl = win_bot[0];
        bc = win_bot[1];
        br = p.pixel;
        if (col_pos >= 2 && row_pos >= 2)
        begin
            gx = (tr - tl) + 2 * (mr - ml) + (br - bl);
            gy = (tl + 2 * tc + tr) - (bl + 2 * bc + br);
            // integer stand-in for sqrt(mag) > threshold
            mag_sq   = gx * gx + gy * gy;
            limit_sq = (int'(thresh_reg) + 1) * (int'(thresh_reg) + 1);
            decision.edge_value    = (mag_sq >= limit_sq) ? EDGE_ON : EDGE_OFF;
            decision.centre_column = OCOL_W'(col_pos - 1);
            decision.centre_row    = OROW_W'(row_pos - 1);
            expected_edges.push_back(decision);
        end
        win_top[0] = win_top[1];
        win_mid[0] = win_mid[1];
        win_bot[0] = win_bot[1];
        win_top[1] = PIX_W'(tr);
        win_mid[1] = PIX_W'(mr);
        win_bot[1] = p.pixel;
        older_row[col_pos] = newer_row[col_pos];
        newer_row[col_pos] = p.pixel;
        // out-of-range widths are clamped into [MIN_WIDTH, DEF_MAX_WIDTH]
        if (width_reg < MIN_WIDTH)
            eff_width = MIN_WIDTH;
        else if (width_reg > DEF_MAX_WIDTH)
            eff_width = DEF_MAX_WIDTH;
        else
            eff_width = width_reg;
        // a column at or past the last one wraps, even after a mid-row narrowing
        if (col_pos + 1 >= eff_width)
        begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= DEF_MAX_HEIGHT) ? 0 : row_pos + 1;
        end
        else
        begin
            col_pos = col_pos + 1;
        end
    endtask

    // One pixel transaction: optional random gap, then hold until accepted
    task automatic send_pixel(input pix_t p);
        while ($urandom_range(0, 99) < send_pct)
        begin
            pix_valid <= 1'b0;
            @(posedge clk);
        end
        pix_valid <= 1'b1;
        pix_data  <= p;
        @(posedge clk);
        while (pix_stall)
            @(posedge clk);
        predict_edge(p);
    endtask

    // Stop sending, let every expected decision arrive, then let the pipeline empty
    task automatic wait_idle();
        int n;
        pix_valid <= 1'b0;
        n = 0;
        while (expected_edges.size() != 0 && n < DRAIN_LIMIT)
        begin
            @(posedge clk);
            n++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register write transaction; called only while the block is idle
    task automatic write_reg(input cfg_idx_e idx, input logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
        if (idx == CFG_LINE_WIDTH)
            width_reg = value[LW_W-1:0];
        else
            thresh_reg = value[THR_W-1:0];
    endtask

    // Stream n_pixels of generated content. start_new puts frame_start on the first
    // pixel; noisy scatters stray frame_start marks that restart the image mid-way.
    task automatic send_frame(input int n_pixels, input bit start_new, input bit noisy);
        texture_e texture;
        int       base;
        int       level;
        pix_t     p;
        texture = texture_e'($urandom_range(0, 2));
        base    = $urandom_range(0, 255);
        for (int k = 0; k < n_pixels; k++)
        begin
            p.frame_start = (start_new && k == 0) || (noisy && $urandom_range(0, 199) == 0);
            case (texture)
                TEX_BINARY:
                    p.pixel = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                TEX_SMOOTH:
                begin
                    level = base + int'($urandom_range(0, 24)) - 12;
                    if (level < 0)
                        level = 0;
                    if (level > 255)
                        level = 255;
                    p.pixel = PIX_W'(level);
                end
                default:
                    p.pixel = PIX_W'($urandom);
            endcase
            send_pixel(p);
        end
    endtask

    // Reset geometry: part of a 2048-pixel first row, so no centre is decided yet
    task automatic test_default_geometry();
        send_pct  = 0;
        stall_pct = 0;
        send_frame(64, 1'b1, 1'b0);
        wait_idle();
    endtask

    // Small hand-built images: width below the minimum, threshold zero and a
    // threshold above anything a 3x3 window can reach
    task automatic test_directed_edges();
        logic [PIX_W-1:0] bars [15];
        pix_t             p;
        send_pct  = 0;
        stall_pct = 0;
        write_reg(CFG_LINE_WIDTH, 12'd0);           // acts as 3
        write_reg(CFG_EDGE_THRESHOLD, 12'd0);
        // flat black centre first (no edge even at zero), then a bright bottom band
        bars = '{8'd0,   8'd0,   8'd0,
                 8'd0,   8'd0,   8'd0,
                 8'd0,   8'd0,   8'd0,
                 8'd255, 8'd0,   8'd255,
                 8'd255, 8'd255, 8'd255};
        for (int k = 0; k < 15; k++)
        begin
            p.pixel       = bars[k];
            p.frame_start = (k == 0);
            send_pixel(p);
        end
        wait_idle();
        // all ones; bit 11 falls outside the threshold field
        write_reg(CFG_EDGE_THRESHOLD, 12'hFFF);
        for (int k = 0; k < 9; k++)
        begin
            p.pixel       = ((k % 2) == 0) ? 8'd255 : 8'd0;
            p.frame_start = (k == 0);
            send_pixel(p);
        end
        wait_idle();
    endtask

    // Width above the maximum clamps to 2048: a short first row decides nothing
    task automatic test_width_clamp_high();
        send_pct  = 0;
        stall_pct = 0;
        write_reg(CFG_LINE_WIDTH, 12'hFFF);
        write_reg(CFG_EDGE_THRESHOLD, 12'd60);
        send_frame(64, 1'b1, 1'b0);
        wait_idle();
    endtask

    // Narrow the line while part-way through a row: the column count is past the
    // new last column, so the next pixel closes the row
    task automatic test_mid_row_narrowing();
        send_pct  = 0;
        stall_pct = 0;
        write_reg(CFG_LINE_WIDTH, 12'd10);
        write_reg(CFG_EDGE_THRESHOLD, 12'd40);
        send_frame(3 * 10 + 7, 1'b1, 1'b0);
        wait_idle();    // mid-row pause until every decision is out
        write_reg(CFG_LINE_WIDTH, 12'd5);
        send_frame(1 + 3 * 5, 1'b0, 1'b0);
        wait_idle();
    endtask

    // Random geometry, thresholds and content under each idling scheme
    task automatic test_random_frames();
        int               sent;
        int               w_code;
        int               eff;
        int               rows;
        int               n;
        logic [CFG_W-1:0] thr;
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin send_pct = 0;  stall_pct = 0;  end
                1:       begin send_pct = 87; stall_pct = 0;  end
                2:       begin send_pct = 0;  stall_pct = 87; end
                default: begin send_pct = 7;  stall_pct = 7;  end
            endcase
            sent = 0;
            while (sent < 220)
            begin
                w_code = $urandom_range(0, 24);
                eff    = (w_code < MIN_WIDTH) ? MIN_WIDTH : w_code;
                case ($urandom_range(0, 5))
                    0:       thr = 12'd0;
                    1:       thr = 12'd1442;
                    2:       thr = 12'h7FF;
                    default: thr = CFG_W'($urandom_range(0, 400));
                endcase
                write_reg(CFG_LINE_WIDTH, CFG_W'(w_code));
                write_reg(CFG_EDGE_THRESHOLD, thr);
                rows = $urandom_range(3, 6);
                // ragged last row on purpose
                n = eff * rows + int'($urandom_range(0, eff - 1));
                send_frame(n, 1'b1, 1'b1);
                wait_idle();
                sent += n;
            end
        end
    endtask

    // Compare each accepted result transaction with the oldest decision
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            if (expected_edges.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual edge %0d col %0d row %0d",
                         $time, res_data.edge_value, res_data.centre_column,
                         res_data.centre_row);
                error_count++;
            end
            else
            begin
                oldest_edge = expected_edges.pop_front();
                if (res_data.edge_value !== oldest_edge.edge_value)
                begin
                    $display("%0t: edge_value mismatch, expected %0d, actual %0d",
                             $time, oldest_edge.edge_value, res_data.edge_value);
                    error_count++;
                end
                if (res_data.centre_column !== oldest_edge.centre_column)
                begin
                    $display("%0t: centre_column mismatch, expected %0d, actual %0d",
                             $time, oldest_edge.centre_column, res_data.centre_column);
                    error_count++;
                end
                if (res_data.centre_row !== oldest_edge.centre_row)
                begin
                    $display("%0t: centre_row mismatch, expected %0d, actual %0d",
                             $time, oldest_edge.centre_row, res_data.centre_row);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        // local state matches the block after reset; line stores are never
        // read before being written, so their start value is irrelevant
        for (int k = 0; k < DEF_MAX_WIDTH; k++)
        begin
            older_row[k] = '0;
            newer_row[k] = '0;
        end
        for (int k = 0; k < 2; k++)
        begin
            win_top[k] = '0;
            win_mid[k] = '0;
            win_bot[k] = '0;
        end
        col_pos    = 0;
        row_pos    = 0;
        width_reg  = LINE_WIDTH_RST;
        thresh_reg = THRESHOLD_RST;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_geometry();
        test_directed_edges();
        test_width_clamp_high();
        test_mid_row_narrowing();
        test_random_frames();

        wait_idle();
        if (expected_edges.size() != 0)
        begin
            $display("%0t: %0d results missing, expected edge %0d col %0d row %0d, actual none",
                     $time, expected_edges.size(), expected_edges[0].edge_value,
                     expected_edges[0].centre_column, expected_edges[0].centre_row);
            error_count++;
        end
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial
    begin
        #40_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

@@ files.f @@
src/sobel_et_pkg.sv
src/sobel_et_ram.sv
src/sobel_et_front.sv
src/sobel_et_decide.sv
src/sobel_edge_threshold.sv
tb/sv/sobel_edge_threshold_tb.sv
